// ===== rtl/bbdq_pkg.sv =====
// Shared types and constants for the byte-budget delay queue.
// Depends on nothing; imported by every module of the block.
package bbdq_pkg;

    // Default queue depth in packet descriptors
    localparam int QUEUE_DEPTH_DEF = 64;

    // Field widths
    localparam int HANDLE_W  = 16;
    localparam int BYTES_W   = 24;
    localparam int TIME_W    = 32;
    localparam int HOLD_W    = 16;
    localparam int DROP_W    = 32;
    localparam int STATUS_W  = 3;
    localparam int REQ_W     = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 24;

    // Register reset values
    localparam logic [HOLD_W-1:0]  HOLD_RESET   = 16'd100;
    localparam logic [BYTES_W-1:0] BUDGET_RESET = 24'd1048576;

    // Request codes; the unused code acts as a pop
    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH  = 2'd0,
        REQ_POP   = 2'd1,
        REQ_FLUSH = 2'd2,
        REQ_SPARE = 2'd3
    } req_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_PUSHED      = 3'd0,
        ST_OVER_BUDGET = 3'd1,
        ST_FULL        = 3'd2,
        ST_POPPED      = 3'd3,
        ST_EMPTY       = 3'd4,
        ST_NOT_AGED    = 3'd5,
        ST_FLUSHED     = 3'd6
    } status_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HOLD_TIME   = 1'd0,
        CFG_BYTE_BUDGET = 1'd1
    } cfg_idx_t;

    // One stored packet descriptor
    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [BYTES_W-1:0]  size;
        logic [TIME_W-1:0]   arrival;
    } entry_t;

    // Per-cell control from the queue controller
    typedef struct packed {
        logic shift;
        logic load;
    } cell_ctl_t;

endpackage

// ===== rtl/bbdq_cell.sv =====
// One storage cell of the shifting descriptor chain.
// Depends on bbdq_pkg for the entry and control types.
module bbdq_cell
    import bbdq_pkg::*;
(
    input  logic      clk,
    input  cell_ctl_t ctl,
    input  entry_t    new_entry,
    input  entry_t    nbr_entry,
    output entry_t    entry
);

    entry_t entry_reg;

    // Load a pushed descriptor, or advance the neighbor's one toward the head
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            entry_reg <= new_entry;
        end
        else if (ctl.shift)
        begin
            entry_reg <= nbr_entry;
        end
    end

    assign entry = entry_reg;

endmodule

// ===== rtl/byte_budget_delay_queue_top.sv =====
// The result of an accepted request is registered and shown, with done high, in the next cycle.
// Throughput: one request per cycle; busy stays low, the queue decision uses only cell 0.
// The descriptor chain shifts one cell toward the head on every pop that returns a descriptor.
// Reset: queue empty, byte and drop counts zero, hold time 100 ms, budget 1048576 bytes.
// Results are strobed for one cycle; the receiver cannot stall them.
// Top level of the byte-budget delay queue; depends on bbdq_pkg and bbdq_cell.
module byte_budget_delay_queue_top
    import bbdq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration write port
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,
    // request side
    input  logic                 start,
    output logic                 busy,
    input  logic [REQ_W-1:0]     req_type,
    input  logic [TIME_W-1:0]    now_ms,
    input  logic [HANDLE_W-1:0]  packet_handle,
    input  logic [BYTES_W-1:0]   packet_bytes,
    // result side
    output logic                 done,
    output logic [STATUS_W-1:0]  status,
    output logic [HANDLE_W-1:0]  out_handle,
    output logic [BYTES_W-1:0]   out_bytes,
    output logic [BYTES_W-1:0]   used_bytes,
    output logic [CNT_W-1:0]     queued_count,
    output logic [DROP_W-1:0]    drop_total
);

    // Configuration registers
    logic [HOLD_W-1:0]  hold_reg;
    logic [BYTES_W-1:0] budget_reg;

    // Queue bookkeeping
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [BYTES_W-1:0] usage_reg, usage_next;
    logic [DROP_W-1:0]  drop_reg, drop_next;

    // Result registers
    logic               done_reg;
    status_t            status_reg, status_next;
    logic [HANDLE_W-1:0] ohandle_reg, ohandle_next;
    logic [BYTES_W-1:0] obytes_reg, obytes_next;

    // Chain control
    logic   accept;
    logic   do_push;
    logic   do_pop;
    entry_t cells [QUEUE_DEPTH];
    entry_t push_entry;
    entry_t head;

    logic [BYTES_W:0]   budget_sum;
    logic [TIME_W-1:0]  elapsed;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign head   = cells[0];

    assign push_entry.handle  = packet_handle;
    assign push_entry.size    = packet_bytes;
    assign push_entry.arrival = now_ms;

    assign budget_sum = {1'b0, usage_reg} + {1'b0, packet_bytes};
    assign elapsed    = now_ms - head.arrival;

    // Decide the request outcome from the counters and the head cell
    always_comb
    begin
        count_next   = count_reg;
        usage_next   = usage_reg;
        drop_next    = drop_reg;
        status_next  = ST_EMPTY;
        ohandle_next = '0;
        obytes_next  = '0;
        do_push      = 1'b0;
        do_pop       = 1'b0;
        case (req_t'(req_type))
            REQ_PUSH:
            begin
                if (budget_sum > {1'b0, budget_reg})
                begin
                    status_next = ST_OVER_BUDGET;
                    drop_next   = (drop_reg == '1) ? drop_reg : drop_reg + 1'b1;
                end
                else if (count_reg >= CNT_W'(QUEUE_DEPTH))
                begin
                    status_next = ST_FULL;
                    drop_next   = (drop_reg == '1) ? drop_reg : drop_reg + 1'b1;
                end
                else
                begin
                    status_next = ST_PUSHED;
                    do_push     = 1'b1;
                    count_next  = count_reg + 1'b1;
                    usage_next  = budget_sum[BYTES_W-1:0];
                end
            end
            REQ_FLUSH:
            begin
                status_next = ST_FLUSHED;
                count_next  = '0;
                usage_next  = '0;
            end
            default:
            begin
                if (count_reg == '0)
                begin
                    status_next = ST_EMPTY;
                end
                else if (elapsed < {{(TIME_W-HOLD_W){1'b0}}, hold_reg})
                begin
                    status_next = ST_NOT_AGED;
                end
                else
                begin
                    status_next  = ST_POPPED;
                    do_pop       = 1'b1;
                    ohandle_next = head.handle;
                    obytes_next  = head.size;
                    count_next   = count_reg - 1'b1;
                    usage_next   = usage_reg - head.size;
                end
            end
        endcase
    end

    // Row of cells: push writes the first free cell, pop advances every cell
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        cell_ctl_t ctl;
        entry_t    nbr;

        assign ctl.load  = accept && do_push && (count_reg == CNT_W'(i));
        assign ctl.shift = accept && do_pop;

        if (i == QUEUE_DEPTH - 1)
        begin : g_last
            assign nbr = cells[i];
        end
        else
        begin : g_mid
            assign nbr = cells[i+1];
        end

        bbdq_cell u_cell (
            .clk       (clk),
            .ctl       (ctl),
            .new_entry (push_entry),
            .nbr_entry (nbr),
            .entry     (cells[i])
        );
    end

    // Hold configuration; the user must write it only while idle, the block itself does not enforce this
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg   <= HOLD_RESET;
            budget_reg <= BUDGET_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_HOLD_TIME:   hold_reg   <= cfg_data[HOLD_W-1:0];
                CFG_BYTE_BUDGET: budget_reg <= cfg_data[BYTES_W-1:0];
                default:         ;
            endcase
        end
    end

    // Advance counters on each accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            usage_reg <= '0;
            drop_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= accept;
            if (accept)
            begin
                count_reg <= count_next;
                usage_reg <= usage_next;
                drop_reg  <= drop_next;
            end
        end
    end

    // Capture the result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg  <= status_next;
            ohandle_reg <= ohandle_next;
            obytes_reg  <= obytes_next;
        end
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign out_handle   = ohandle_reg;
    assign out_bytes    = obytes_reg;
    assign used_bytes   = usage_reg;
    assign queued_count = count_reg;
    assign drop_total   = drop_reg;

    // Occupancy never passes the chain length
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    // An empty queue holds no bytes
    a_empty_no_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (usage_reg == '0))
        else $error("bytes held with empty queue");

    // A reported pop removed exactly one descriptor
    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && status_reg == ST_POPPED) |-> (count_reg + 1'b1 == $past(count_reg)))
        else $error("pop did not remove one entry");

    // Drop total never decreases
    a_drop_mono: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (drop_reg >= $past(drop_reg)))
        else $error("drop total decreased");

endmodule
